[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by bitmap_block_allocator and bba_checker.
package bba_pkg;

    localparam int DEF_MAX_BLOCKS    = 4096;
    localparam int DEF_MAP_WORD_BITS = 32;   // power of two

    localparam int ZONE_W   = 13;
    localparam int BLOCK_W  = 12;
    localparam int STATUS_W = 2;

    localparam logic [ZONE_W-1:0] ZONE_COUNT_RESET = 13'd4096;

    typedef logic [ZONE_W-1:0]   zone_t;
    typedef logic [BLOCK_W-1:0]  block_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_OUT_OF_BLOCKS = 2'd1;
    localparam status_t ST_BAD_FREE      = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage

[rtl/bba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bitmap_block_allocator.sv]
// Bitmap block allocator top level: first-fit allocate / free over a used map.
// Depends on bba_pkg and bba_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, func, block_number): one transfer is one
//   request. func = allocate returns the lowest free block below the active
//   limit min(zone_count, MAX_BLOCKS); func = free clears the block's bit.
//   Output channel (out_valid/out_ready, status, granted_block): one transfer
//   per request, in request order.
//   Config: cfg_wr_en/cfg_wr_data write zone_count; write only while idle.
// Sequence (accept to out_valid), ending in S_FINISH for every request:
//   allocate: S_CHECK reads k map words, one RAM read per cycle, until a
//     free bit is found (k = 1 .. ceil(limit / MAP_WORD_BITS)), so 128 words
//     worst case at default; this word scan sets the rate. free: S_CHECK.
//   Free at or beyond the limit, or allocate with a zero limit, skips S_CHECK.
//   One request is in flight at a time; in_ready is high when the engine is
//   idle, even if the previous result still sits in the output register.
// Reset: map rows are marked invalid (read as all free), zone_count = 4096.
//   No clearing pass is needed.
// Stall: a result waits in the engine until the output register frees up.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
    parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  bba_pkg::block_t  block_number,
    output logic             out_valid,
    input  logic             out_ready,
    output bba_pkg::status_t status,
    output bba_pkg::block_t  granted_block,
    input  logic             cfg_wr_en,
    input  bba_pkg::zone_t   cfg_wr_data
);

    import bba_pkg::*;

    localparam int DEPTH  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SH     = $clog2(MAP_WORD_BITS);
    localparam int MB_W   = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W  = (MB_W > ZONE_W) ? MB_W : ZONE_W;
    localparam int BASE_W = LIM_W + 1;
    localparam int W      = MAP_WORD_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // registers
    logic [1:0]        state_reg, state_next;
    logic              op_free_reg, op_free_next;
    block_t            blk_reg, blk_next;
    logic [AW-1:0]     word_idx_reg, word_idx_next;
    logic [BASE_W-1:0] base_reg, base_next;
    status_t           res_status_reg, res_status_next;
    block_t            res_block_reg, res_block_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    block_t            out_block_reg, out_block_next;
    logic [DEPTH-1:0]  row_valid_reg, row_valid_next;
    zone_t             zone_count_reg;

    // datapath
    logic              accept;
    logic [LIM_W-1:0]  lim;
    logic [LIM_W-1:0]  rem;
    logic [AW-1:0]     rd_addr;
    logic [W-1:0]      rd_data;
    logic [W-1:0]      word;
    logic [W-1:0]      mask;
    logic [W-1:0]      cand;
    logic [W-1:0]      low_onehot;
    logic [SH-1:0]     find_idx;
    logic              found;
    logic [W-1:0]      bit_onehot;
    logic              bit_set;
    logic [BASE_W-1:0] base_step;
    logic              last_word;
    logic              ram_we;
    logic [W-1:0]      ram_wdata;
    logic              out_free;

    // active limit saturates at MAX_BLOCKS
    always_comb
    begin
        if (LIM_W'(zone_count_reg) > LIM_W'(MAX_BLOCKS))
        begin
            lim = LIM_W'(MAX_BLOCKS);
        end
        else
        begin
            lim = LIM_W'(zone_count_reg);
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // first read on accept, then the next word of the scan
    assign rd_addr = accept ? ((func == FUNC_FREE) ? AW'(block_number >> SH) : '0)
                            : word_idx_reg + AW'(1);

    // rows never written read as all free
    assign word = row_valid_reg[word_idx_reg] ? rd_data : '0;

    // mask off bits at or beyond the limit in the current word
    assign rem = lim - base_reg[LIM_W-1:0];
    always_comb
    begin
        if (rem >= LIM_W'(W))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({W{1'b1}} << rem[SH-1:0]);
        end
    end

    assign cand       = ~word & mask;
    assign found      = |cand;
    assign low_onehot = cand & (~cand + W'(1));

    always_comb
    begin
        find_idx = '0;
        for (int i = 0; i < W; i++)
        begin
            if (low_onehot[i])
            begin
                find_idx = find_idx | SH'(i);
            end
        end
    end

    assign bit_onehot = W'(1) << blk_reg[SH-1:0];
    assign bit_set    = |(word & bit_onehot);
    assign base_step  = base_reg + BASE_W'(W);
    assign last_word  = base_step >= BASE_W'(lim);

    assign ram_we    = (state_reg == S_CHECK) && (op_free_reg ? bit_set : found);
    assign ram_wdata = op_free_reg ? (word & ~bit_onehot) : (word | low_onehot);

    always_comb
    begin
        state_next      = state_reg;
        op_free_next    = op_free_reg;
        blk_next        = blk_reg;
        word_idx_next   = word_idx_reg;
        base_next       = base_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        row_valid_next  = row_valid_reg;

        if (ram_we)
        begin
            row_valid_next[word_idx_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_free_next  = func;
                    blk_next      = block_number;
                    word_idx_next = rd_addr;
                    base_next     = '0;
                    state_next    = S_CHECK;
                    if (func == FUNC_FREE)
                    begin
                        res_block_next = block_number;
                        if (!(LIM_W'(block_number) < lim))
                        begin
                            res_status_next = ST_BAD_FREE;
                            state_next      = S_FINISH;
                        end
                    end
                    else if (lim == '0)
                    begin
                        res_status_next = ST_OUT_OF_BLOCKS;
                        res_block_next  = '0;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_CHECK:
            begin
                if (op_free_reg)
                begin
                    res_status_next = bit_set ? ST_OK : ST_BAD_FREE;
                    state_next      = S_FINISH;
                end
                else if (found)
                begin
                    res_status_next = ST_OK;
                    res_block_next  = BLOCK_W'(base_reg + BASE_W'(find_idx));
                    state_next      = S_FINISH;
                end
                else if (last_word)
                begin
                    res_status_next = ST_OUT_OF_BLOCKS;
                    res_block_next  = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    word_idx_next = rd_addr;
                    base_next     = base_step;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            zone_count_reg <= ZONE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
            if (cfg_wr_en)
            begin
                zone_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        op_free_reg    <= op_free_next;
        blk_reg        <= blk_next;
        word_idx_reg   <= word_idx_next;
        base_reg       <= base_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
    end

    bba_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (word_idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_block = out_block_reg;

endmodule

[rtl/bba_checker.sv]
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             func,
    input bba_pkg::block_t  block_number,
    input logic             out_valid,
    input logic             out_ready,
    input bba_pkg::status_t status,
    input bba_pkg::block_t  granted_block
);

    import bba_pkg::*;

    logic       push;
    logic       pop;
    logic [1:0] cnt_reg;
    logic       head_func_reg;
    block_t     head_blk_reg;
    logic       tail_func_reg;
    block_t     tail_blk_reg;

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // requests accepted but not yet delivered: at most one in the output
    // register and one in the engine; head is the one on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        begin
            head_func_reg <= func;
            head_blk_reg  <= block_number;
        end
        else if (pop)
        begin
            head_func_reg <= tail_func_reg;
            head_blk_reg  <= tail_blk_reg;
        end
        if (push)
        begin
            tail_func_reg <= func;
            tail_blk_reg  <= block_number;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_block))
        else $error("result changed under stall");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back-to-back accept");

    // free results echo the block number
    a_free_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head_func_reg == FUNC_FREE |-> granted_block == head_blk_reg)
        else $error("free result does not echo block");

    // out-of-blocks only on allocate, with block zero
    a_oob: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OUT_OF_BLOCKS
            |-> head_func_reg == FUNC_ALLOC && granted_block == '0)
        else $error("bad out-of-blocks result");

    // bad-free only on free
    a_bad_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_FREE |-> head_func_reg == FUNC_FREE)
        else $error("bad-free status on allocate");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .block_number  (block_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_block (granted_block)
);
